FILE: rtl/utf8_decode_display_width_unit_macros.svh
// Assertion helpers for the checker file udw_checker.sv.
`ifndef UTF8_DECODE_DISPLAY_WIDTH_UNIT_MACROS_SVH
`define UTF8_DECODE_DISPLAY_WIDTH_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UDW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udw check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define UDW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udw check failed");

`endif

FILE: rtl/udw_pkg.sv
package udw_pkg;

    localparam int WIDTH_BITS_DEF = 16;
    localparam int Q_DEPTH        = 2;

    localparam logic [20:0] CP_MAX  = 21'h10FFFF;
    localparam logic [20:0] SURR_LO = 21'h00D800;
    localparam logic [20:0] SURR_HI = 21'h00DFFF;
    localparam logic [20:0] MIN_2B  = 21'h000080;
    localparam logic [20:0] MIN_3B  = 21'h000800;
    localparam logic [20:0] MIN_4B  = 21'h010000;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_BAD
    } byte_class_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic        char_done;
        logic [20:0] code_point;
        logic [1:0]  char_columns;
        logic [15:0] total_columns;
        logic        all_valid;
        logic        string_end;
    } out_t;

    typedef struct packed {
        byte_class_t cls;
        logic [7:0]  data_byte;
        logic        last_byte;
    } q_entry_t;

    typedef struct packed {
        logic [20:0] lo;
        logic [20:0] hi;
    } span_t;

    localparam span_t ZERO_SPANS [5] = '{
        '{lo: 21'h0300, hi: 21'h036F}, '{lo: 21'h1AB0, hi: 21'h1AFF},
        '{lo: 21'h1DC0, hi: 21'h1DFF}, '{lo: 21'h20D0, hi: 21'h20FF},
        '{lo: 21'hFE20, hi: 21'hFE2F}
    };

    localparam span_t WIDE_SPANS [10] = '{
        '{lo: 21'h1100, hi: 21'h115F},   '{lo: 21'h2329, hi: 21'h232A},
        '{lo: 21'h2E80, hi: 21'hA4CF},   '{lo: 21'hAC00, hi: 21'hD7A3},
        '{lo: 21'hF900, hi: 21'hFAFF},   '{lo: 21'hFE10, hi: 21'hFE19},
        '{lo: 21'hFE30, hi: 21'hFE6F},   '{lo: 21'hFF00, hi: 21'hFF60},
        '{lo: 21'hFFE0, hi: 21'hFFE6},   '{lo: 21'h1F300, hi: 21'h1FAFF}
    };

    function automatic logic [1:0] columns_of(input logic [20:0] cp);
        logic is_zero;
        logic is_wide;
        is_zero = (cp < 21'h20) || (cp >= 21'h7F && cp < 21'hA0);
        is_wide = 1'b0;
        for (int k = 0; k < 5; k++)
        begin
            if (cp >= ZERO_SPANS[k].lo && cp <= ZERO_SPANS[k].hi)
            begin
                is_zero = 1'b1;
            end
        end
        for (int k = 0; k < 10; k++)
        begin
            if (cp >= WIDE_SPANS[k].lo && cp <= WIDE_SPANS[k].hi)
            begin
                is_wide = 1'b1;
            end
        end
        if (is_zero)
        begin
            return 2'd0;
        end
        else if (is_wide)
        begin
            return 2'd2;
        end
        return 2'd1;
    endfunction

endpackage

FILE: rtl/udw_front.sv
module udw_front (
    input  logic              in_valid,
    output logic              in_ready,
    input  udw_pkg::in_t      in_payload,
    output logic              push_valid,
    input  logic              push_ready,
    output udw_pkg::q_entry_t push_entry
);

    udw_pkg::byte_class_t cls;

    always_comb
    begin
        unique case (in_payload.data_byte) inside
            [8'h00:8'h7F]: cls = udw_pkg::CLS_ASCII;
            [8'h80:8'hBF]: cls = udw_pkg::CLS_CONT;
            [8'hC0:8'hDF]: cls = udw_pkg::CLS_LEAD2;
            [8'hE0:8'hEF]: cls = udw_pkg::CLS_LEAD3;
            [8'hF0:8'hF7]: cls = udw_pkg::CLS_LEAD4;
            default:       cls = udw_pkg::CLS_BAD;
        endcase
    end

    assign in_ready             = push_ready;
    assign push_valid           = in_valid;
    assign push_entry.cls       = cls;
    assign push_entry.data_byte = in_payload.data_byte;
    assign push_entry.last_byte = in_payload.last_byte;

endmodule

FILE: rtl/udw_queue.sv
module udw_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  udw_pkg::q_entry_t push_entry,
    output logic              pop_valid,
    input  logic              pop_ready,
    output udw_pkg::q_entry_t pop_entry
);

    localparam int PtrW = (udw_pkg::Q_DEPTH > 1) ? $clog2(udw_pkg::Q_DEPTH) : 1;
    localparam int CntW = $clog2(udw_pkg::Q_DEPTH + 1);

    udw_pkg::q_entry_t slot_reg [udw_pkg::Q_DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CntW'(udw_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(udw_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(udw_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/udw_back.sv
module udw_back #(
    parameter int WIDTH_BITS = udw_pkg::WIDTH_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  udw_pkg::q_entry_t pop_entry,
    output logic              out_valid,
    input  logic              out_ready,
    output udw_pkg::out_t     out_payload
);

    logic [20:0]           partial_reg, partial_next;
    logic [2:0]            need_reg, need_next;
    logic [1:0]            held_reg, held_next;
    logic [WIDTH_BITS-1:0] run_reg, run_next;
    logic                  valid_reg, valid_next;
    logic                  out_valid_reg;
    udw_pkg::out_t         out_reg, out_next;

    logic                  pop;
    logic                  lead;
    logic [20:0]           v;
    logic [2:0]            held_inc;
    logic [20:0]           minv;
    logic [2:0]            add;
    logic                  done;
    logic [20:0]           cp;
    logic [1:0]            cols;
    logic [WIDTH_BITS:0]   sum;
    logic [WIDTH_BITS-1:0] run_sat;
    logic [31:0]           run_ext;

    assign pop_ready   = !out_valid_reg || out_ready;
    assign pop         = pop_valid && pop_ready;
    assign out_valid   = out_valid_reg;
    assign out_payload = out_reg;

    assign v        = {partial_reg[14:0], pop_entry.data_byte[5:0]};
    assign held_inc = {1'b0, held_reg} + 3'd1;

    always_comb
    begin
        unique case (need_reg)
            3'd2:    minv = udw_pkg::MIN_2B;
            3'd3:    minv = udw_pkg::MIN_3B;
            default: minv = udw_pkg::MIN_4B;
        endcase
    end

    always_comb
    begin
        partial_next = partial_reg;
        need_next    = need_reg;
        held_next    = held_reg;
        valid_next   = valid_reg;
        add          = 3'd0;
        done         = 1'b0;
        cp           = '0;
        cols         = 2'd0;
        lead         = 1'b1;

        if (need_reg != 3'd0)
        begin
            if (pop_entry.cls == udw_pkg::CLS_CONT)
            begin
                lead = 1'b0;
                if (held_inc >= need_reg)
                begin
                    if (v < minv || (v >= udw_pkg::SURR_LO && v <= udw_pkg::SURR_HI)
                        || v > udw_pkg::CP_MAX)
                    begin
                        add        = need_reg;
                        valid_next = 1'b0;
                    end
                    else
                    begin
                        done = 1'b1;
                        cp   = v;
                        cols = udw_pkg::columns_of(v);
                        add  = {1'b0, cols};
                    end
                    partial_next = '0;
                    need_next    = 3'd0;
                    held_next    = 2'd0;
                end
                else
                begin
                    partial_next = v;
                    held_next    = held_inc[1:0];
                end
            end
            else
            begin
                // broken sequence: charge its bytes, then treat this byte as a lead
                add          = {1'b0, held_reg};
                valid_next   = 1'b0;
                partial_next = '0;
                need_next    = 3'd0;
                held_next    = 2'd0;
            end
        end

        if (lead)
        begin
            unique case (pop_entry.cls) inside
                udw_pkg::CLS_ASCII:
                begin
                    done = 1'b1;
                    cp   = {13'd0, pop_entry.data_byte};
                    cols = udw_pkg::columns_of(cp);
                    add  = add + {1'b0, cols};
                end
                udw_pkg::CLS_LEAD2:
                begin
                    need_next    = 3'd2;
                    held_next    = 2'd1;
                    partial_next = {16'd0, pop_entry.data_byte[4:0]};
                end
                udw_pkg::CLS_LEAD3:
                begin
                    need_next    = 3'd3;
                    held_next    = 2'd1;
                    partial_next = {17'd0, pop_entry.data_byte[3:0]};
                end
                udw_pkg::CLS_LEAD4:
                begin
                    need_next    = 3'd4;
                    held_next    = 2'd1;
                    partial_next = {18'd0, pop_entry.data_byte[2:0]};
                end
                udw_pkg::CLS_CONT, udw_pkg::CLS_BAD:
                begin
                    add        = add + 3'd1;
                    valid_next = 1'b0;
                end
                default:
                begin
                    add        = add + 3'd1;
                    valid_next = 1'b0;
                end
            endcase
        end

        // flush a sequence left open at the end of the string
        if (pop_entry.last_byte && need_next != 3'd0)
        begin
            add          = add + {1'b0, held_next};
            valid_next   = 1'b0;
            partial_next = '0;
            need_next    = 3'd0;
            held_next    = 2'd0;
        end
    end

    assign sum     = {1'b0, run_reg} + (WIDTH_BITS + 1)'(add);
    assign run_sat = sum[WIDTH_BITS] ? '1 : sum[WIDTH_BITS-1:0];
    assign run_ext = 32'(run_sat);

    always_comb
    begin
        out_next.char_done     = done;
        out_next.code_point    = cp;
        out_next.char_columns  = cols;
        out_next.total_columns = run_ext[15:0];
        out_next.all_valid     = valid_next;
        out_next.string_end    = pop_entry.last_byte;
        run_next               = run_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            need_reg      <= 3'd0;
            held_reg      <= 2'd0;
            run_reg       <= '0;
            valid_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (pop_entry.last_byte)
                begin
                    partial_reg <= '0;
                    need_reg    <= 3'd0;
                    held_reg    <= 2'd0;
                    run_reg     <= '0;
                    valid_reg   <= 1'b1;
                end
                else
                begin
                    partial_reg <= partial_next;
                    need_reg    <= need_next;
                    held_reg    <= held_next;
                    run_reg     <= run_next;
                    valid_reg   <= valid_next;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: rtl/utf8_decode_display_width_unit.sv
// An accepted byte is written into the queue, then decoded into the output register.
// Throughput: one byte per cycle unless the output stalls; back-end decode state
// updates per byte, and a two-entry queue lets the input run while a result waits.
// Reset (rst_n low, asynchronous) empties the queue and output register and clears
// the decode state; the running width clears and all_valid goes high.
module utf8_decode_display_width_unit #(
    parameter int WIDTH_BITS = udw_pkg::WIDTH_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  udw_pkg::in_t  in_payload,
    output logic          out_valid,
    input  logic          out_ready,
    output udw_pkg::out_t out_payload
);

    logic              push_valid, push_ready;
    logic              pop_valid, pop_ready;
    udw_pkg::q_entry_t push_entry, pop_entry;

    udw_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_payload (in_payload),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    udw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    udw_back #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_entry   (pop_entry),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_payload (out_payload)
    );

endmodule

FILE: rtl/udw_checker.sv
`include "utf8_decode_display_width_unit_macros.svh"

module udw_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input udw_pkg::in_t  in_payload,
    input logic          out_valid,
    input logic          out_ready,
    input udw_pkg::out_t out_payload
);

    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    // a stalled result holds
    `UDW_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

    // with the output register empty the queue cannot be full
    `UDW_ASSERT_IMP(a_ready_when_drained, !out_valid, in_ready)

    // after every accepted byte the output register holds a result, its own or an earlier stalled one
    `UDW_ASSERT_NXT(a_result_follows, in_xfer, ##1 out_valid)

    // no code point or width without a completed character
    `UDW_ASSERT_IMP(a_idle_fields_zero, out_valid && !out_payload.char_done,
                    out_payload.code_point == 21'd0 && out_payload.char_columns == 2'd0)

endmodule

bind utf8_decode_display_width_unit udw_checker u_udw_checker (.*);

FILE: bench/udw_width_checker.sv
`timescale 1ns / 100ps

module udw_width_checker #(
    parameter int WIDTH_BITS = udw_pkg::WIDTH_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  udw_pkg::in_t  in_payload,
    input  logic          out_valid,
    input  logic          out_ready,
    input  udw_pkg::out_t out_payload,
    output int            mismatches,
    output int            pending,
    output int            checked,
    output int            strings_seen,
    output int            bad_strings,
    output int            sat_results
);

    localparam logic [32:0] COL_MAX = (33'd1 << WIDTH_BITS) - 33'd1;

    // Decoder state as the predictor sees it
    logic [20:0] acc;
    logic [2:0]  need;
    logic [2:0]  held;
    logic [32:0] run_cols;
    logic        ok_so_far;

    udw_pkg::out_t predicted_chars [$];

    initial
    begin
        mismatches   = 0;
        pending      = 0;
        checked      = 0;
        strings_seen = 0;
        bad_strings  = 0;
        sat_results  = 0;
    end

    function automatic logic in_span(input logic [20:0] cp, input logic [20:0] lo,
                                     input logic [20:0] hi);
        return (cp >= lo) && (cp <= hi);
    endfunction

    function automatic logic [1:0] display_cols(input logic [20:0] cp);
        if (cp < 21'h20 || in_span(cp, 21'h7F, 21'h9F))
        begin
            return 2'd0;
        end
        // combining marks
        if (in_span(cp, 21'h0300, 21'h036F) || in_span(cp, 21'h1AB0, 21'h1AFF) ||
            in_span(cp, 21'h1DC0, 21'h1DFF) || in_span(cp, 21'h20D0, 21'h20FF) ||
            in_span(cp, 21'hFE20, 21'hFE2F))
        begin
            return 2'd0;
        end
        // East Asian wide, Hangul, fullwidth forms, emoji
        if (in_span(cp, 21'h1100, 21'h115F) || in_span(cp, 21'h2329, 21'h232A) ||
            in_span(cp, 21'h2E80, 21'hA4CF) || in_span(cp, 21'hAC00, 21'hD7A3) ||
            in_span(cp, 21'hF900, 21'hFAFF) || in_span(cp, 21'hFE10, 21'hFE19) ||
            in_span(cp, 21'hFE30, 21'hFE6F) || in_span(cp, 21'hFF00, 21'hFF60) ||
            in_span(cp, 21'hFFE0, 21'hFFE6) || in_span(cp, 21'h1F300, 21'h1FAFF))
        begin
            return 2'd2;
        end
        return 2'd1;
    endfunction

    function automatic udw_pkg::byte_class_t classify(input logic [7:0] b);
        if (!b[7])
        begin
            return udw_pkg::CLS_ASCII;
        end
        else if (b[7:6] == 2'b10)
        begin
            return udw_pkg::CLS_CONT;
        end
        else if (b[7:5] == 3'b110)
        begin
            return udw_pkg::CLS_LEAD2;
        end
        else if (b[7:4] == 4'b1110)
        begin
            return udw_pkg::CLS_LEAD3;
        end
        else if (b[7:3] == 5'b11110)
        begin
            return udw_pkg::CLS_LEAD4;
        end
        return udw_pkg::CLS_BAD;
    endfunction

    task automatic add_cols(input int n);
        logic [32:0] sum;
        sum = run_cols + 33'(n);
        run_cols = (sum > COL_MAX) ? COL_MAX : sum;
    endtask

    task automatic clear_seq();
        acc  = '0;
        need = '0;
        held = '0;
    endtask

    task automatic fail_seq();
        add_cols(int'(held));
        ok_so_far = 1'b0;
        clear_seq();
    endtask

    task automatic clear_all();
        clear_seq();
        run_cols  = '0;
        ok_so_far = 1'b1;
    endtask

    task automatic decode_step(input udw_pkg::in_t item, output udw_pkg::out_t res);
        udw_pkg::byte_class_t cls;
        logic                 lead;
        logic                 done;
        logic [20:0]          cp;
        logic [1:0]           cols;
        logic [20:0]          minv;
        cls  = classify(item.data_byte);
        lead = 1'b1;
        done = 1'b0;
        cp   = '0;
        cols = '0;
        if (need != 0)
        begin
            if (cls == udw_pkg::CLS_CONT)
            begin
                lead = 1'b0;
                acc  = {acc[14:0], item.data_byte[5:0]};
                held = held + 3'd1;
                if (held >= need)
                begin
                    minv = (need == 3'd2) ? udw_pkg::MIN_2B :
                           (need == 3'd3) ? udw_pkg::MIN_3B : udw_pkg::MIN_4B;
                    // overlong, surrogate and out-of-range values show only when complete
                    if (acc < minv || in_span(acc, udw_pkg::SURR_LO, udw_pkg::SURR_HI) ||
                        acc > udw_pkg::CP_MAX)
                    begin
                        add_cols(int'(need));
                        ok_so_far = 1'b0;
                    end
                    else
                    begin
                        done = 1'b1;
                        cp   = acc;
                        cols = display_cols(acc);
                        add_cols(int'(cols));
                    end
                    clear_seq();
                end
            end
            else
            begin
                // breaking byte: fail what is held, then treat the byte as a lead
                fail_seq();
            end
        end
        if (lead)
        begin
            case (cls)
                udw_pkg::CLS_ASCII:
                begin
                    done = 1'b1;
                    cp   = {13'd0, item.data_byte};
                    cols = display_cols(cp);
                    add_cols(int'(cols));
                end
                udw_pkg::CLS_LEAD2:
                begin
                    need = 3'd2;
                    held = 3'd1;
                    acc  = {16'd0, item.data_byte[4:0]};
                end
                udw_pkg::CLS_LEAD3:
                begin
                    need = 3'd3;
                    held = 3'd1;
                    acc  = {17'd0, item.data_byte[3:0]};
                end
                udw_pkg::CLS_LEAD4:
                begin
                    need = 3'd4;
                    held = 3'd1;
                    acc  = {18'd0, item.data_byte[2:0]};
                end
                default:
                begin
                    add_cols(1);
                    ok_so_far = 1'b0;
                end
            endcase
        end
        if (item.last_byte && need != 0)
        begin
            fail_seq();
        end
        res.char_done     = done;
        res.code_point    = cp;
        res.char_columns  = cols;
        res.total_columns = run_cols[15:0];
        res.all_valid     = ok_so_far;
        res.string_end    = item.last_byte;
        if (run_cols == COL_MAX)
        begin
            sat_results++;
        end
        if (item.last_byte)
        begin
            strings_seen++;
            if (!ok_so_far)
            begin
                bad_strings++;
            end
            clear_all();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        udw_pkg::out_t want;
        udw_pkg::out_t fresh;
        if (!rst_n)
        begin
            clear_all();
            predicted_chars.delete();
        end
        else
        begin
            // compare first: a result never belongs to the byte of the same edge
            if (out_valid && out_ready)
            begin
                if (predicted_chars.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = predicted_chars.pop_front();
                    check_field("char_done", 32'(want.char_done),
                                32'(out_payload.char_done));
                    check_field("code_point", 32'(want.code_point),
                                32'(out_payload.code_point));
                    check_field("char_columns", 32'(want.char_columns),
                                32'(out_payload.char_columns));
                    check_field("total_columns", 32'(want.total_columns),
                                32'(out_payload.total_columns));
                    check_field("all_valid", 32'(want.all_valid),
                                32'(out_payload.all_valid));
                    check_field("string_end", 32'(want.string_end),
                                32'(out_payload.string_end));
                    checked++;
                end
            end
            if (in_valid && in_ready)
            begin
                decode_step(in_payload, fresh);
                predicted_chars.push_back(fresh);
            end
        end
        pending <= predicted_chars.size();
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam logic [20:0] EDGE_CPS [0:45] = '{
        21'h00000, 21'h0001F, 21'h00020, 21'h0007E, 21'h0007F, 21'h0009F, 21'h000A0,
        21'h002FF, 21'h00300, 21'h0036F, 21'h00370, 21'h007FF, 21'h00800, 21'h01100,
        21'h0115F, 21'h01AB0, 21'h01AFF, 21'h01DC0, 21'h01DFF, 21'h020D0, 21'h020FF,
        21'h02329, 21'h0232A, 21'h02E80, 21'h0A4CF, 21'h0AC00, 21'h0D7A3, 21'h0E000,
        21'h0F900, 21'h0FAFF, 21'h0FE10, 21'h0FE19, 21'h0FE20, 21'h0FE2F, 21'h0FE30,
        21'h0FE6F, 21'h0FF00, 21'h0FF60, 21'h0FFE0, 21'h0FFE6, 21'h0FFFF, 21'h10000,
        21'h1F300, 21'h1FAFF, 21'h10FFFE, 21'h10FFFF
    };

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    udw_pkg::in_t  in_payload;
    logic          out_valid;
    logic          out_ready;
    udw_pkg::out_t out_payload;

    int mismatches;
    int pending;
    int checked;
    int strings_seen;
    int bad_strings;
    int sat_results;

    bit gaps_on;
    bit drops_on;
    int hold_reqs;
    int hold_seen;
    int hold_left;
    int bytes_sent;

    logic [7:0] str_bytes [$];

    utf8_decode_display_width_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_payload (in_payload),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_payload(out_payload)
    );

    udw_width_checker #(
        .WIDTH_BITS(udw_pkg::WIDTH_BITS_DEF)
    ) width_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_payload  (in_payload),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_payload (out_payload),
        .mismatches  (mismatches),
        .pending     (pending),
        .checked     (checked),
        .strings_seen(strings_seen),
        .bad_strings (bad_strings),
        .sat_results (sat_results)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        #4ms;
        $display("tb: done, errors");
        $finish;
    end

    // Result side: random stalls, plus long hold-offs on request
    initial
    begin
        hold_seen = 0;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = 80;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= !(drops_on && $urandom_range(99) < 28);
            end
        end
    end

    function automatic int min_len(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            return 1;
        end
        else if (cp < 21'h800)
        begin
            return 2;
        end
        else if (cp < 21'h10000)
        begin
            return 3;
        end
        return 4;
    endfunction

    function automatic logic [20:0] pick_cp();
        int          r;
        logic [20:0] v;
        r = $urandom_range(99);
        if (r < 30)
        begin
            return 21'($urandom_range(127));
        end
        if (r < 45)
        begin
            return 21'($urandom_range(21'h80, 21'h7FF));
        end
        if (r < 60)
        begin
            v = 21'($urandom_range(21'h800, 21'hFFFF));
            // steer clear of the surrogate block
            if (v >= 21'hD800 && v <= 21'hDFFF)
            begin
                v = v - 21'h1000;
            end
            return v;
        end
        if (r < 72)
        begin
            return 21'($urandom_range(21'h10000, 21'h10FFFF));
        end
        v = 21'(EDGE_CPS[$urandom_range($size(EDGE_CPS) - 1)] + $urandom_range(2) - 1);
        if (v > 21'h10FFFF)
        begin
            v = 21'h10FFFF;
        end
        return v;
    endfunction

    // Encode cp into n bytes; n above the minimum gives an overlong form
    task automatic add_cp(input logic [20:0] cp, input int n);
        case (n)
            1:
            begin
                str_bytes.push_back({1'b0, cp[6:0]});
            end
            2:
            begin
                str_bytes.push_back({3'b110, cp[10:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                str_bytes.push_back({4'b1110, cp[15:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                str_bytes.push_back({5'b11110, cp[20:18]});
                str_bytes.push_back({2'b10, cp[17:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (gaps_on && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_payload <= '{data_byte: b, last_byte: last};
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_string();
        foreach (str_bytes[i])
        begin
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
        end
    endtask

    task automatic random_string();
        int          units;
        int          noise_pct;
        logic [20:0] cp;
        str_bytes.delete();
        units     = $urandom_range(1, 10);
        noise_pct = ($urandom_range(99) < 40) ? 0 : 20;
        repeat (units)
        begin
            if ($urandom_range(99) < noise_pct)
            begin
                case ($urandom_range(5))
                    0:
                    begin
                        str_bytes.push_back(8'($urandom_range(255)));
                    end
                    1:
                    begin
                        // truncated sequence: breaks on the next lead or stays open at end
                        cp = 21'($urandom_range(21'h80, 21'h10FFFF));
                        add_cp(cp, min_len(cp));
                        void'(str_bytes.pop_back());
                    end
                    2:
                    begin
                        cp = 21'($urandom_range(21'hFFFF));
                        add_cp(cp, $urandom_range(min_len(cp) + 1, 4));
                    end
                    3:
                    begin
                        add_cp(21'($urandom_range(21'hD800, 21'hDFFF)), 3);
                    end
                    4:
                    begin
                        add_cp(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
                    end
                    default:
                    begin
                        str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    end
                endcase
            end
            else
            begin
                cp = pick_cp();
                add_cp(cp, min_len(cp));
            end
        end
        send_string();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   <= 1'b0;
        in_payload <= '0;
        gaps_on    = 1'b1;
        drops_on   = 1'b1;
        hold_reqs  = 0;
        bytes_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // NUL, DEL, bad leads at both ends of the byte range
        str_bytes = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        send_string();
        // overlong, surrogate, above the top code point
        str_bytes = '{8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80};
        send_string();
        // broken sequence, emoji, sequence left open at the end
        str_bytes = '{8'hE4, 8'hB8, 8'h41, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE4};
        send_string();
        // highest valid code point
        str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();

        // stretch with no idling on either side
        gaps_on  = 1'b0;
        drops_on = 1'b0;
        while (bytes_sent < 225)
        begin
            random_string();
        end

        gaps_on  = 1'b1;
        drops_on = 1'b1;
        while (bytes_sent < 670)
        begin
            if ((hold_reqs == 0 && bytes_sent >= 400) || (hold_reqs == 1 && bytes_sent >= 600))
            begin
                hold_reqs++;
            end
            random_string();
        end

        // overlong pair, then a wide character and a plain letter
        str_bytes = '{8'hC0, 8'h80, 8'hE4, 8'hB8, 8'h80, 8'h41};
        send_string();
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("tb: %0d bytes sent in %0d strings, %0d results checked",
                 bytes_sent, strings_seen, checked);
        $display("tb: %0d strings ended malformed, %0d results at the width ceiling",
                 bad_strings, sat_results);
        if (mismatches == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
